/* rtl/dcf_pkg.sv */
`default_nettype none
package dcf_pkg;
	localparam int STATIONS = 8;
	localparam int SW = $clog2(STATIONS);
	localparam int CW = $clog2(STATIONS + 1);
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] SLOT_US = 48'd9;
	localparam logic [47:0] ACK_US = 48'd50;
	localparam logic [47:0] BUSY_US = 48'd1492;
	localparam logic [47:0] DIFS_US = 48'd28;

	localparam logic [2:0] REG_ACTIVE = 3'd0;
	localparam logic [2:0] REG_WMIN = 3'd1;
	localparam logic [2:0] REG_WMAX = 3'd2;
	localparam logic [2:0] REG_RETRY = 3'd3;
	localparam logic [2:0] REG_PKTS = 3'd4;
	localparam logic [2:0] REG_SEED = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COUNT, ST_STATION, ST_MOD, ST_NEXT, ST_OUT
	} state_t;
endpackage
`default_nettype wire

/* rtl/dcf_backoff_contention.sv */
// DCF backoff contention model, one slot per input item.
// Input channel: in_valid/in_stall carry restart (1 = reload stations and
// clear totals, 0 = one slot tick). Output channel: out_valid/out_stall
// carry one result per item: slot status and running totals.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; written only
// while idle: the user must keep to this, the block does not enforce it.
// cfg_ready is always high. A tick counts the ready stations, then visits
// each station in turn with a step between stations, and then presents its
// result; a restart skips the count. Each backoff draw adds 32 steps of a
// bit-serial 32/10 remainder unit shared by all stations, then a store of
// the result. The next item can be accepted in the cycle after the result
// is taken. The block takes no new item until its result has been taken;
// while the receiver stalls the result holds on the output registers.
// Reset: all stations idle, LFSR at one, totals zero, registers at their
// defaults; the first restart loads the stations.
`default_nettype none
module dcf_backoff_contention (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic restart,
	output logic out_valid,
	input wire logic out_stall,
	output logic [3:0] ready_count,
	output logic success,
	output logic collision,
	output logic [2:0] winner,
	output logic [3:0] drops_now,
	output logic [31:0] sent_total,
	output logic [31:0] dropped_total,
	output logic [31:0] collision_total,
	output logic [31:0] contention_total,
	output logic [47:0] elapsed_us,
	output logic all_done,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import dcf_pkg::*;

	// configuration
	logic [3:0] active_q, retry_lim_q;
	logic [9:0] wmin_q, wmax_q;
	logic [19:0] pkts_q;
	logic [31:0] seed_q;

	// station state
	logic [9:0] backoff_q [STATIONS];
	logic [9:0] window_q [STATIONS];
	logic [3:0] retries_q [STATIONS];
	logic [19:0] left_q [STATIONS];
	logic [31:0] lfsr_q, sent_q, drop_q, coll_q, cont_q;
	logic [47:0] time_q;

	// sequencer
	state_t state_q, state_d;
	logic restart_q;
	logic [SW-1:0] idx_q;
	logic [CW-1:0] ready_q;
	logic [3:0] drops_q;
	logic succ_q;
	logic [2:0] win_q;
	logic [9:0] div_q;
	logic [31:0] dvd_q;
	logic [9:0] rem_q;
	logic [5:0] bit_q;

	// present-station helpers
	logic part_i, last_i, draw_i;
	logic [3:0] rinc_i;
	logic [10:0] nw_i;
	logic [9:0] wnew_i;
	logic [19:0] lnew_i;
	logic [31:0] lfsr_nx;
	logic [CW-1:0] cnt_c;
	logic [10:0] rtry;
	logic done_c;

	assign cfg_ready = 1'b1;
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
	assign last_i = (32'(idx_q) == STATIONS - 1);
	assign part_i = ({28'd0, active_q} > 32'(idx_q)) && (left_q[idx_q] != 20'd0);
	assign rinc_i = retries_q[idx_q] + 4'd1;
	assign nw_i = {window_q[idx_q], 1'b1};
	assign rtry = {rem_q, dvd_q[31]};

	// new window, packets left, and whether a draw follows, for this station
	always_comb begin
		wnew_i = window_q[idx_q];
		lnew_i = left_q[idx_q];
		draw_i = 1'b0;
		if (restart_q) begin
			wnew_i = wmin_q;
			lnew_i = ({28'd0, active_q} > 32'(idx_q)) ? pkts_q : 20'd0;
			draw_i = (lnew_i != 20'd0);
		end else if (part_i && backoff_q[idx_q] == 10'd0) begin
			if (ready_q == CW'(1)) begin
				wnew_i = wmin_q;
				lnew_i = left_q[idx_q] - 20'd1;
			end else if (rinc_i >= retry_lim_q) begin
				wnew_i = wmin_q;
				lnew_i = left_q[idx_q] - 20'd1;
			end else begin
				wnew_i = (nw_i >= {1'b0, wmax_q}) ? wmax_q : nw_i[9:0];
			end
			draw_i = (lnew_i != 20'd0);
		end
	end

	// ready count and done flag across stations
	always_comb begin
		cnt_c = '0;
		done_c = 1'b1;
		for (int i = 0; i < STATIONS; i++) begin
			if ({28'd0, active_q} > 32'(i) && left_q[i] != 20'd0) begin
				done_c = 1'b0;
				if (backoff_q[i] == 10'd0) cnt_c = cnt_c + CW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = restart ? ST_STATION : ST_COUNT;
			ST_COUNT: state_d = ST_STATION;
			ST_STATION: state_d = draw_i ? ST_MOD : (last_i ? ST_OUT : ST_NEXT);
			ST_MOD: if (bit_q == 6'd32) state_d = last_i ? ST_OUT : ST_NEXT;
			ST_NEXT: state_d = ST_STATION;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd8;
			wmin_q <= 10'd15;
			wmax_q <= 10'd1023;
			retry_lim_q <= 4'd7;
			pkts_q <= 20'd100000;
			seed_q <= 32'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACTIVE: active_q <= cfg_data[3:0];
				REG_WMIN: wmin_q <= cfg_data[9:0];
				REG_WMAX: wmax_q <= cfg_data[9:0];
				REG_RETRY: retry_lim_q <= cfg_data[3:0];
				REG_PKTS: pkts_q <= cfg_data[19:0];
				REG_SEED: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STATIONS; i++) begin
				backoff_q[i] <= '0;
				window_q[i] <= '0;
				retries_q[i] <= '0;
				left_q[i] <= '0;
			end
			lfsr_q <= 32'd1;
			sent_q <= '0;
			drop_q <= '0;
			coll_q <= '0;
			cont_q <= '0;
			time_q <= '0;
			restart_q <= 1'b0;
			idx_q <= '0;
			ready_q <= '0;
			drops_q <= '0;
			succ_q <= 1'b0;
			win_q <= '0;
			div_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					restart_q <= restart;
					idx_q <= '0;
					ready_q <= '0;
					drops_q <= '0;
					succ_q <= 1'b0;
					win_q <= '0;
					if (restart) begin
						lfsr_q <= (seed_q == 32'd0) ? 32'd1 : seed_q;
						sent_q <= '0;
						drop_q <= '0;
						coll_q <= '0;
						cont_q <= '0;
						time_q <= DIFS_US;
					end else begin
						time_q <= sat_add(time_q, SLOT_US);
					end
				end
				ST_COUNT: begin
					ready_q <= cnt_c;
					if (cnt_c != '0) begin
						cont_q <= cont_q + 32'd1;
						time_q <= sat_add(time_q, BUSY_US);
						if (cnt_c != CW'(1)) coll_q <= coll_q + 32'd1;
					end
				end
				ST_STATION: begin
					window_q[idx_q] <= wnew_i;
					left_q[idx_q] <= lnew_i;
					if (restart_q) begin
						retries_q[idx_q] <= '0;
						backoff_q[idx_q] <= '0;
					end else if (part_i) begin
						if (backoff_q[idx_q] != 10'd0) begin
							if (ready_q == '0) backoff_q[idx_q] <= backoff_q[idx_q] - 10'd1;
						end else begin
							backoff_q[idx_q] <= '0;
							if (ready_q == CW'(1)) begin
								succ_q <= 1'b1;
								win_q <= 3'(idx_q);
								retries_q[idx_q] <= '0;
								sent_q <= sent_q + 32'd1;
								time_q <= sat_add(time_q, ACK_US);
							end else if (rinc_i >= retry_lim_q) begin
								retries_q[idx_q] <= '0;
								drop_q <= drop_q + 32'd1;
								if (drops_q != 4'd15) drops_q <= drops_q + 4'd1;
							end else begin
								retries_q[idx_q] <= rinc_i;
							end
						end
					end
					if (draw_i) begin
						lfsr_q <= lfsr_nx;
						dvd_q <= lfsr_nx;
						div_q <= wnew_i;
						rem_q <= '0;
						bit_q <= '0;
					end
				end
				ST_MOD: begin
					// one restoring remainder step per cycle
					if (bit_q != 6'd32) begin
						if (rtry >= {1'b0, div_q}) rem_q <= 10'(rtry - {1'b0, div_q});
						else rem_q <= rtry[9:0];
						dvd_q <= {dvd_q[30:0], 1'b0};
						bit_q <= bit_q + 6'd1;
					end else begin
						backoff_q[idx_q] <= (div_q == 10'd0) ? 10'd0 : rem_q;
					end
				end
				ST_NEXT: idx_q <= idx_q + SW'(1);
				default: ;
			endcase
		end
	end

	assign ready_count = 4'(ready_q);
	assign success = succ_q;
	assign collision = (ready_q > CW'(1));
	assign winner = win_q;
	assign drops_now = drops_q;
	assign sent_total = sent_q;
	assign dropped_total = drop_q;
	assign collision_total = coll_q;
	assign contention_total = cont_q;
	assign elapsed_us = time_q;
	assign all_done = done_c;

	a_succ_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && success |-> ready_q == CW'(1)) else $error("success without single ready");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(success && collision)) else $error("success and collision");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD && div_q != 10'd0 |-> rem_q < div_q) else $error("remainder range");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> in_stall) else $error("accepting while busy");
endmodule
`default_nettype wire

/* bench/dcf_backoff_contention_tb.sv */
`default_nettype none
module dcf_backoff_contention_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dcf_pkg::*;

	typedef struct packed {
		logic [3:0] ready_count;
		logic success;
		logic collision;
		logic [2:0] winner;
		logic [3:0] drops_now;
		logic [31:0] sent_total;
		logic [31:0] dropped_total;
		logic [31:0] collision_total;
		logic [31:0] contention_total;
		logic [47:0] elapsed_us;
		logic all_done;
	} slot_result_t;

	typedef struct {
		logic rs;
		bit known;
		slot_result_t val;
	} slot_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, restart;
	logic out_valid, out_stall;
	logic [3:0] ready_count;
	logic success, collision;
	logic [2:0] winner;
	logic [3:0] drops_now;
	logic [31:0] sent_total, dropped_total, collision_total, contention_total;
	logic [47:0] elapsed_us;
	logic all_done;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	dcf_backoff_contention DUT (.*);

	// configuration mirror
	logic [3:0] act_stations = 4'd8;
	logic [9:0] wmin = 10'd15, wmax = 10'd1023;
	logic [3:0] retry_lim = 4'd7;
	logic [19:0] pkts_per_sta = 20'd100000;
	logic [31:0] seed = 32'd1;

	// per-station contention state
	logic [9:0] backoff [STATIONS];
	logic [9:0] cwin [STATIONS];
	logic [3:0] retr [STATIONS];
	logic [19:0] pkts [STATIONS];
	logic [31:0] lfsr_q = 32'd1;
	logic [31:0] sent_q, drop_q, coll_q, cont_q;
	logic [47:0] clock_us;

	slot_result_t slot_q[$];
	int errors = 0;
	int items = 0;
	bit calm = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [9:0] draw_backoff(logic [9:0] w);
		lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
		return (w == 0) ? 10'd0 : 10'(lfsr_q % w);
	endfunction

	function automatic void add_us(logic [47:0] us);
		logic [48:0] s;
		s = {1'b0, clock_us} + us;
		clock_us = s[48] ? TIME_MAX : s[47:0];
	endfunction

	function automatic bit in_contention(int i);
		return i < act_stations && pkts[i] != 0;
	endfunction

	// advance the slot model by one item
	function automatic slot_result_t predict_slot(logic rs);
		slot_result_t r;
		int nready, ndrops;
		logic [10:0] nw;
		bit done;
		r = '0;
		nready = 0;
		ndrops = 0;
		done = 1;
		if (rs) begin
			lfsr_q = (seed != 0) ? seed : 32'd1;
			for (int i = 0; i < STATIONS; i++) begin
				retr[i] = 0;
				cwin[i] = wmin;
				backoff[i] = 0;
				pkts[i] = (i < act_stations) ? pkts_per_sta : 20'd0;
				if (pkts[i] != 0)
					backoff[i] = draw_backoff(cwin[i]);
			end
			sent_q = 0;
			drop_q = 0;
			coll_q = 0;
			cont_q = 0;
			clock_us = DIFS_US;
		end else begin
			for (int i = 0; i < STATIONS; i++)
				if (in_contention(i) && backoff[i] == 0)
					nready++;
			add_us(SLOT_US);
			for (int i = 0; i < STATIONS; i++) begin
				if (!in_contention(i))
					continue;
				if (backoff[i] != 0) begin
					if (nready == 0)
						backoff[i]--;
					continue;
				end
				if (nready == 1) begin
					r.success = 1;
					r.winner = 3'(i);
					cwin[i] = wmin;
					retr[i] = 0;
					pkts[i]--;
					sent_q++;
					add_us(ACK_US);
				end else begin
					retr[i] = retr[i] + 4'd1;
					if (retr[i] >= retry_lim) begin
						ndrops++;
						drop_q++;
						cwin[i] = wmin;
						retr[i] = 0;
						pkts[i]--;
					end else begin
						nw = {cwin[i], 1'b1};
						cwin[i] = (nw >= wmax) ? wmax : nw[9:0];
					end
				end
				backoff[i] = (pkts[i] != 0) ? draw_backoff(cwin[i]) : 10'd0;
			end
			if (nready > 0) begin
				cont_q++;
				add_us(BUSY_US);
				if (nready > 1) begin
					r.collision = 1;
					coll_q++;
				end
			end
		end
		for (int i = 0; i < STATIONS; i++)
			if (in_contention(i))
				done = 0;
		r.ready_count = (nready > 15) ? 4'd15 : 4'(nready);
		r.drops_now = (ndrops > 15) ? 4'd15 : 4'(ndrops);
		r.sent_total = sent_q;
		r.dropped_total = drop_q;
		r.collision_total = coll_q;
		r.contention_total = cont_q;
		r.elapsed_us = clock_us;
		r.all_done = done;
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ACTIVE: act_stations = d[3:0];
			REG_WMIN: wmin = d[9:0];
			REG_WMAX: wmax = d[9:0];
			REG_RETRY: retry_lim = d[3:0];
			REG_PKTS: pkts_per_sta = d[19:0];
			REG_SEED: seed = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_slot(logic rs, bit known = 0, slot_result_t typed = '0);
		slot_result_t r;
		int g;
		in_valid <= 1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		r = predict_slot(rs);
		slot_q.push_back(known ? typed : r);
		items++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (slot_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic setup(logic [3:0] a, logic [9:0] lo, logic [9:0] hi, logic [3:0] rl,
		logic [19:0] p, logic [31:0] s);
		write_reg(REG_ACTIVE, {28'($urandom) , a});
		write_reg(REG_WMIN, {22'($urandom), lo});
		write_reg(REG_WMAX, {22'($urandom), hi});
		write_reg(REG_RETRY, {28'($urandom), rl});
		write_reg(REG_PKTS, {12'($urandom), p});
		write_reg(REG_SEED, s);
	endtask

	task automatic check_field(string nm, logic [47:0] e, logic [47:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		slot_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (slot_q.size() == 0) begin
				$display("%0t: unexpected result item", $time);
				errors++;
			end else begin
				e = slot_q.pop_front();
				check_field("ready_count", 48'(e.ready_count), 48'(ready_count));
				check_field("success", 48'(e.success), 48'(success));
				check_field("collision", 48'(e.collision), 48'(collision));
				check_field("winner", 48'(e.winner), 48'(winner));
				check_field("drops_now", 48'(e.drops_now), 48'(drops_now));
				check_field("sent_total", 48'(e.sent_total), 48'(sent_total));
				check_field("dropped_total", 48'(e.dropped_total), 48'(dropped_total));
				check_field("collision_total", 48'(e.collision_total),
					48'(collision_total));
				check_field("contention_total", 48'(e.contention_total),
					48'(contention_total));
				check_field("elapsed_us", e.elapsed_us, elapsed_us);
				check_field("all_done", 48'(e.all_done), 48'(all_done));
			end
		end
	end

	// receiver stalls, with one long hold-off so the block backs up
	initial begin
		bit held;
		int p;
		held = 0;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			p = $urandom_range(0, 99);
			if (!held && items >= 500) begin
				held = 1;
				out_stall <= 1;
				repeat (300) @(negedge clk);
			end else if (calm || p < 65) begin
				out_stall <= 0;
			end else begin
				out_stall <= 1;
				repeat ((p < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40))
					@(negedge clk);
			end
		end
	end

	initial begin
		slot_row_t rows[$];
		slot_row_t row;
		int n;
		logic [31:0] rw;
		for (int i = 0; i < STATIONS; i++) begin
			backoff[i] = 0;
			cwin[i] = 0;
			retr[i] = 0;
			pkts[i] = 0;
		end
		sent_q = 0;
		drop_q = 0;
		coll_q = 0;
		cont_q = 0;
		clock_us = 0;
		arst_n = 0;
		in_valid = 0;
		restart = 0;
		cfg_valid = 0;
		cfg_index = REG_ACTIVE;
		cfg_data = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed rows: idle ticks before any restart, then default contention
		row = '{1'b0, 1'b1, '0};
		row.val.elapsed_us = 48'd9;
		row.val.all_done = 1;
		rows.push_back(row);
		row.val.elapsed_us = 48'd18;
		rows.push_back(row);
		row = '{1'b1, 1'b1, '0};
		row.val.elapsed_us = DIFS_US;
		rows.push_back(row);
		for (int k = 0; k < 12; k++)
			rows.push_back('{1'b0, 1'b0, '0});
		rows.push_back(row);
		for (int k = 0; k < 6; k++)
			rows.push_back('{1'b0, 1'b0, '0});
		foreach (rows[k])
			send_slot(rows[k].rs, rows[k].known, rows[k].val);
		drain();

		// unused register indexes are ignored
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);

		// fixed corners, then random settings
		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0: setup(4'd1, 10'd1, 10'd1, 4'd1, 20'd1, 32'hFFFF_FFFF);
				1: setup(4'd8, 10'd0, 10'd0, 4'd0, 20'd3, 32'd0);
				2: setup(4'd8, 10'd1, 10'd1023, 4'd4, 20'd4, 32'hA5A5_1234);
				3: setup(4'd15, 10'd3, 10'd7, 4'd2, 20'd0, 32'd7);
				4: setup(4'd8, 10'd1023, 10'd1023, 4'd15, 20'hFFFFF, 32'h5A5A_EDCB);
				5: setup(4'd0, 10'd15, 10'd1023, 4'd7, 20'd10, 32'd3);
				6: setup(4'd3, 10'd0, 10'd1023, 4'd15, 20'd5, 32'd5);
				7: setup(4'd8, 10'd15, 10'd1023, 4'd7, 20'd100000, 32'd1);
				default: begin
					rw = $urandom;
					setup(4'($urandom_range(1, 8)), 10'($urandom_range(0, 31)),
						10'($urandom_range(1, 1023)), 4'($urandom_range(0, 15)),
						($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 8)),
						rw);
				end
			endcase
			calm = (ph % 4 == 3);
			n = (ph == 4) ? 40 : 90;
			send_slot(1'b1);
			for (int k = 0; k < n; k++)
				send_slot(($urandom_range(0, 29) == 0) ? 1'b1 : 1'b0);
			drain();
		end

		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
